// File: hdl/sacwb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacwb_pkg
// Shared types and constants of the set-associative write-back tag unit.
// ----------------------------------------------------------------------------
package sacwb_pkg;

    // configuration port
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

    // register reset values
    localparam logic [4:0] OFFSET_BITS_RST = 5'd4;
    localparam logic [3:0] INDEX_BITS_RST  = 4'd0;
    localparam logic [3:0] WAYS_IN_USE_RST = 4'd1;

    // widest raw set index (index_bits is a 4-bit register)
    localparam int IDX_RAW_W = 15;
    // tag shift amount: offset_bits + index_bits
    localparam int SHIFT_W   = 6;
    // output beat width
    localparam int OUT_W     = 8;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SET_Q,
        ST_SET_R,
        ST_LOOKUP,
        ST_REDUCE
    } sacwb_state_t;

endpackage

// File: hdl/set_assoc_writeback_cache_tags_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_writeback_cache_tags_unit
// Tag, valid and dirty store of a set-associative write-back cache with
// round-robin victim choice, one set row per memory word.
// ----------------------------------------------------------------------------
//  channel  | dir | beat contents (lowest bit first)
//  ---------+-----+---------------------------------------------------------
//  s_*      | in  | tdata: address[31:0]; tuser: is_store
//  m_*      | out | tdata: hit, writeback, way_used[2:0], zero fill
//  cfg_*    | in  | write: 0 offset_bits, 1 index_bits, 2 ways_in_use
//
//  An access reads its set row, then compares tags and writes the row back
//  through the single RAM; when MAX_SETS is not a power of two the set index
//  modulo is worked out in ST_SET_Q and ST_SET_R before the row is read.
//  A miss whose stored victim pointer is at or above the ways in use takes
//  up the pointer in ST_REDUCE and there subtracts the way count from it
//  until it lies below the ways in use.
//  After reset a clearing pass zeroes every row; no beat is accepted
//  meanwhile, configuration writes are taken.
//  A new beat is accepted while a finished result still waits in the output
//  register; the lookup holds until that register is free.
// ----------------------------------------------------------------------------
module set_assoc_writeback_cache_tags_unit #(
    parameter int ADDR_BITS = 32,
    parameter int MAX_SETS  = 256,
    parameter int MAX_WAYS  = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [sacwb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sacwb_pkg::CFG_W-1:0]     cfg_data,
    // access stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // address[31:0]
    input  logic                            s_tuser,   // is_store
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sacwb_pkg::OUT_W-1:0]     m_tdata    // hit, writeback, way_used[2:0]
);

    import sacwb_pkg::*;

    localparam int  SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int  WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int  CNT_W     = $clog2(MAX_WAYS + 1);
    localparam int  ENT_W     = ADDR_BITS + 2;
    localparam int  ROW_W     = MAX_WAYS * ENT_W + WAY_W;
    localparam bit  SETS_POW2 = ((MAX_SETS & (MAX_SETS - 1)) == 0);
    // reciprocal for the set index modulo when MAX_SETS is not a power of two
    localparam int  LOG_M     = $clog2(MAX_SETS);
    localparam int  MOD_S     = IDX_RAW_W + LOG_M;
    localparam longint MOD_POW = longint'(1) << MOD_S;
    localparam longint RECIP   = (MOD_POW + longint'(MAX_SETS) - 1) / longint'(MAX_SETS);

    // configuration registers
    logic [4:0] offset_reg;
    logic [3:0] index_reg;
    logic [3:0] ways_reg;

    // sequencer and access registers
    sacwb_state_t           state_reg, state_next;
    logic [SET_W-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [ADDR_BITS-1:0]   tag_reg, tag_next;
    logic                   store_reg, store_next;
    logic [SET_W-1:0]       set_reg, set_next;
    logic [IDX_RAW_W-1:0]   raw_idx_reg, raw_idx_next;
    logic [IDX_RAW_W-1:0]   q_reg, q_next;
    logic [WAY_W-1:0]       ptr_reg, ptr_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic                   hit_reg, hit_next;
    logic                   wb_reg, wb_next;
    logic [2:0]             way_reg, way_next;

    // RAM ports
    logic                   ram_we, ram_re;
    logic [SET_W-1:0]       ram_waddr, ram_raddr;
    logic [ROW_W-1:0]       ram_wdata, ram_rdata;

    // address split of the incoming beat
    logic [95:0]               addr_pad;
    logic [ADDR_BITS-1:0]      addr_ext;
    logic [SHIFT_W-1:0]        tag_shift;
    logic [ADDR_BITS+14:0]     idx_shifted;
    logic [15:0]               idx_mask;
    logic [IDX_RAW_W-1:0]      raw_idx_in;
    logic [SET_W-1:0]          set_pow2_in;

    // modulo datapath
    logic [31:0]               q_prod;
    logic [31:0]               qm_prod;
    logic [15:0]               rem_raw;
    logic [15:0]               rem_fix;

    // lookup datapath
    logic [7:0]                ways_pad;
    logic [CNT_W-1:0]          ways_act;
    logic [MAX_WAYS-1:0]       match;
    logic                      hit_any;
    logic [WAY_W-1:0]          hit_way;
    logic [WAY_W-1:0]          row_ptr;
    logic [WAY_W-1:0]          victim;
    logic                      victim_ok;
    logic [WAY_W-1:0]          found;
    logic [ENT_W-1:0]          old_ent;
    logic [ENT_W-1:0]          new_ent;
    logic [CNT_W-1:0]          found_inc;
    logic [WAY_W-1:0]          new_ptr;
    logic [CNT_W-1:0]          ptr_diff;
    logic [WAY_W+2:0]          found_pad;
    logic                      out_free;
    logic                      finish;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OFFSET_BITS_RST;
            index_reg  <= INDEX_BITS_RST;
            ways_reg   <= WAYS_IN_USE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OFFSET_BITS: offset_reg <= cfg_data;
                REG_INDEX_BITS:  index_reg  <= cfg_data[3:0];
                REG_WAYS_IN_USE: ways_reg   <= cfg_data[3:0];
                default:         ;
            endcase
        end
    end

    // address split
    always_comb
    begin
        addr_pad    = {64'd0, s_tdata};
        addr_ext    = addr_pad[ADDR_BITS-1:0];
        tag_shift   = {1'b0, offset_reg} + {2'b00, index_reg};
        idx_shifted = {15'd0, addr_ext} >> offset_reg;
        idx_mask    = (16'd1 << index_reg) - 16'd1;
        raw_idx_in  = idx_shifted[IDX_RAW_W-1:0] & idx_mask[IDX_RAW_W-1:0];
        set_pow2_in = SET_W'(raw_idx_in & IDX_RAW_W'(MAX_SETS - 1));
    end

    // set index modulo by reciprocal multiplication
    always_comb
    begin
        q_prod  = 32'(raw_idx_reg) * 32'(RECIP);
        qm_prod = 32'(q_reg) * 32'(MAX_SETS);
        rem_raw = 16'(raw_idx_reg) - qm_prod[15:0];
        if ({1'b0, rem_raw} >= 17'(MAX_SETS))
        begin
            rem_fix = rem_raw - 16'(MAX_SETS);
        end
        else
        begin
            rem_fix = rem_raw;
        end
    end

    // active way count, 0 acts as 1, saturates at MAX_WAYS
    always_comb
    begin
        ways_pad = {4'd0, ways_reg};
        if (ways_pad == 8'd0)
        begin
            ways_pad = 8'd1;
        end
        else if (ways_pad > 8'(MAX_WAYS))
        begin
            ways_pad = 8'(MAX_WAYS);
        end
        ways_act = ways_pad[CNT_W-1:0];
    end

    // tag compare over the ways in use, lowest way wins
    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            match[w] = (w < int'(ways_act))
                       && ram_rdata[w*ENT_W + ADDR_BITS]
                       && (ram_rdata[w*ENT_W +: ADDR_BITS] == tag_reg);
        end
        hit_any = |match;
        hit_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                hit_way = WAY_W'(w);
            end
        end
    end

    // victim choice and row update
    always_comb
    begin
        row_ptr   = ram_rdata[ROW_W-1 -: WAY_W];
        victim    = (state_reg == ST_LOOKUP) ? row_ptr : ptr_reg;
        victim_ok = (CNT_W'(victim) < ways_act);
        found     = hit_any ? hit_way : victim;
        old_ent   = ram_rdata[found*ENT_W +: ENT_W];
        if (hit_any)
        begin
            new_ent = old_ent;
            new_ent[ADDR_BITS+1] = old_ent[ADDR_BITS+1] | store_reg;
        end
        else
        begin
            new_ent = {store_reg, 1'b1, tag_reg};
        end
        found_inc = CNT_W'(found) + CNT_W'(1);
        new_ptr   = (found_inc == ways_act) ? '0 : WAY_W'(found_inc);
        ptr_diff  = CNT_W'(ptr_reg) - ways_act;
        found_pad = {3'b000, found};
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        tag_next       = tag_reg;
        store_next     = store_reg;
        set_next       = set_reg;
        raw_idx_next   = raw_idx_reg;
        q_next         = q_reg;
        ptr_next       = ptr_reg;
        s_tready       = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = set_reg;
        ram_we         = 1'b0;
        ram_waddr      = set_reg;
        ram_wdata      = ram_rdata;
        finish         = 1'b0;
        out_free       = !out_valid_reg || m_tready;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + SET_W'(1);
                if (clr_cnt_reg == SET_W'(MAX_SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    tag_next     = addr_ext >> tag_shift;
                    store_next   = s_tuser;
                    raw_idx_next = raw_idx_in;
                    if (SETS_POW2)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = set_pow2_in;
                        set_next   = set_pow2_in;
                        state_next = ST_LOOKUP;
                    end
                    else
                    begin
                        state_next = ST_SET_Q;
                    end
                end
            end
            ST_SET_Q:
            begin
                q_next     = IDX_RAW_W'(q_prod >> MOD_S);
                state_next = ST_SET_R;
            end
            ST_SET_R:
            begin
                ram_re     = 1'b1;
                ram_raddr  = SET_W'(rem_fix);
                set_next   = SET_W'(rem_fix);
                state_next = ST_LOOKUP;
            end
            ST_LOOKUP, ST_REDUCE:
            begin
                if (hit_any || victim_ok)
                begin
                    if (out_free)
                    begin
                        finish    = 1'b1;
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata;
                        ram_wdata[found*ENT_W +: ENT_W] = new_ent;
                        ram_wdata[ROW_W-1 -: WAY_W]     = new_ptr;
                        state_next = ST_IDLE;
                    end
                end
                else if (state_reg == ST_LOOKUP)
                begin
                    ptr_next   = row_ptr;
                    state_next = ST_REDUCE;
                end
                else
                begin
                    ptr_next = WAY_W'(ptr_diff);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register next values
    always_comb
    begin
        out_valid_next = out_valid_reg;
        hit_next       = hit_reg;
        wb_next        = wb_reg;
        way_next       = way_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
            hit_next       = hit_any;
            wb_next        = !hit_any && old_ent[ADDR_BITS] && old_ent[ADDR_BITS+1];
            way_next       = found_pad[2:0];
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        tag_reg     <= tag_next;
        store_reg   <= store_next;
        set_reg     <= set_next;
        raw_idx_reg <= raw_idx_next;
        q_reg       <= q_next;
        ptr_reg     <= ptr_next;
        hit_reg     <= hit_next;
        wb_reg      <= wb_next;
        way_reg     <= way_next;
    end

    // set row store: per way {dirty, valid, tag}, victim pointer on top
    sacwb_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, way_reg, wb_reg, hit_reg};

    // a row write never coincides with a new beat
    a_no_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !(s_tvalid && s_tready))
        else $error("row write during beat acceptance");

    // a hit never flags a write-back
    a_hit_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(hit_reg && wb_reg))
        else $error("write-back flagged on a hit");

    // a finished lookup shows a result next cycle
    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> out_valid_reg)
        else $error("finished lookup without result");

    // stored victim pointer stays below the ways in use
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg != ST_CLEAR) |-> (CNT_W'(new_ptr) < ways_act))
        else $error("victim pointer out of range");

endmodule

// File: hdl/sacwb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacwb_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sacwb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the set-associative write-back tag unit: a
// directed table and then random phases of cache accesses under changing
// geometry, beats scored against a behavioural cache model or pinned rows.
// ----------------------------------------------------------------------------
module tb;
    import sacwb_pkg::*;

    localparam int   SETS        = 256;
    localparam int   WAYS        = 8;
    localparam int   PHASES      = 8;
    localparam int   PHASE_BEATS = 80;
    localparam int   DRAIN_LIMIT = 20000;
    localparam int   PRINT_LIMIT = 50;
    localparam logic LOAD        = 1'b0;
    localparam logic STORE       = 1'b1;

    typedef struct packed {
        logic       hit;
        logic       writeback;
        logic [2:0] way;
    } access_result_t;

    // one row of the directed table: a geometry change or an access
    typedef struct packed {
        logic           geometry;
        logic [4:0]     off;
        logic [3:0]     idx;
        logic [3:0]     ways;
        logic [31:0]    addr;
        logic           store;
        logic           pinned;
        access_result_t res;
    } stim_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata   = '0;   // address[31:0]
    logic                 s_tuser   = 1'b0; // is_store
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [OUT_W-1:0]     m_tdata;          // hit, writeback, way_used[2:0]

    bit             calm        = 1'b0;
    int             error_count = 0;
    int             stall_left  = 0;
    access_result_t due_results[$];

    // model of the tag store and its geometry
    logic [63:0] tag_mem     [SETS][WAYS];
    bit          line_valid  [SETS][WAYS];
    bit          line_dirty  [SETS][WAYS];
    int unsigned next_victim [SETS];
    int unsigned cur_offset = OFFSET_BITS_RST;
    int unsigned cur_index  = INDEX_BITS_RST;
    int unsigned cur_ways   = WAYS_IN_USE_RST;

    always #2 clk = ~clk;

    set_assoc_writeback_cache_tags_unit #(
        .ADDR_BITS (32),
        .MAX_SETS  (SETS),
        .MAX_WAYS  (WAYS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // look up one access, update the model and return the expected beat
    function automatic access_result_t lookup_line(logic [31:0] addr, logic store);
        int unsigned    ways;
        int unsigned    set;
        int unsigned    found;
        logic [63:0]    wide;
        logic [63:0]    imask;
        logic [63:0]    tag;
        access_result_t r;
        // ways 0 acts as one, above the maximum saturates
        ways  = (cur_ways == 0) ? 1 : ((cur_ways > WAYS) ? WAYS : cur_ways);
        wide  = {32'd0, addr};
        imask = (64'd1 << cur_index) - 64'd1;
        // set index beyond the table wraps
        set   = int'(((wide >> cur_offset) & imask) % SETS);
        tag   = wide >> (cur_offset + cur_index);
        found = ways;
        for (int w = 0; w < ways; w++)
        begin
            if (found == ways && line_valid[set][w] && tag_mem[set][w] == tag)
                found = w;
        end
        r = '0;
        if (found < ways)
        begin
            r.hit = 1'b1;
            if (store)
                line_dirty[set][found] = 1'b1;
        end
        else
        begin
            // a stale pointer after shrinking the ways wraps
            found                  = next_victim[set] % ways;
            r.writeback            = line_valid[set][found] && line_dirty[set][found];
            tag_mem[set][found]    = tag;
            line_valid[set][found] = 1'b1;
            line_dirty[set][found] = store;
        end
        next_victim[set] = (found + 1) % ways;
        r.way            = 3'(found);
        return r;
    endfunction

    function automatic stim_row_t access_row(logic [31:0] addr, logic store);
        stim_row_t r;
        r       = '0;
        r.addr  = addr;
        r.store = store;
        return r;
    endfunction

    function automatic stim_row_t pinned_row(logic [31:0] addr, logic store, logic hit,
                                             logic wb, logic [2:0] way);
        stim_row_t r;
        r             = access_row(addr, store);
        r.pinned      = 1'b1;
        r.res.hit     = hit;
        r.res.writeback = wb;
        r.res.way     = way;
        return r;
    endfunction

    function automatic stim_row_t geometry_row(logic [4:0] off, logic [3:0] idx,
                                               logic [3:0] ways);
        stim_row_t r;
        r          = '0;
        r.geometry = 1'b1;
        r.off      = off;
        r.idx      = idx;
        r.ways     = ways;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (error_count < PRINT_LIMIT)
            $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_OFFSET_BITS: cur_offset = val;
            REG_INDEX_BITS:  cur_index  = val[3:0];
            REG_WAYS_IN_USE: cur_ways   = val[3:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(logic [4:0] off, logic [3:0] idx, logic [3:0] ways);
        write_reg(REG_OFFSET_BITS, off);
        write_reg(REG_INDEX_BITS, CFG_W'(idx));
        write_reg(REG_WAYS_IN_USE, CFG_W'(ways));
        cfg_we <= 1'b0;
    endtask

    // hold the sender until every result is back, then let a miss settle
    task automatic drain();
        int spins;
        spins     = 0;
        s_tvalid <= 1'b0;
        while (due_results.size() != 0 && spins < DRAIN_LIMIT)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (16) @(posedge clk);
    endtask

    task automatic idle_gap(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_access(logic [31:0] addr, logic store, logic pinned,
                               access_result_t pin_res);
        access_result_t r;
        s_tvalid <= 1'b1;
        s_tdata  <= addr;
        s_tuser  <= store;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = lookup_line(addr, store);
        due_results.push_back(pinned ? pin_res : r);
    endtask

    // result side back-pressure in bursts
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end
        else if (!calm && $urandom_range(0, 11) == 0)
        begin
            stall_left <= $urandom_range(1, 19);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // score each result beat against the oldest expectation
    always @(posedge clk)
    begin : score_beat
        access_result_t want;
        access_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.hit       = m_tdata[0];
            got.writeback = m_tdata[1];
            got.way       = m_tdata[4:2];
            if (due_results.size() == 0)
                report_mismatch($sformatf("result beat %h with nothing outstanding", m_tdata));
            else
            begin
                want = due_results.pop_front();
                if (got !== want || m_tdata[OUT_W-1:5] !== '0)
                    report_mismatch($sformatf(
                        "hit %b/%b writeback %b/%b way %0d/%0d fill %h (got/want)",
                        got.hit, want.hit, got.writeback, want.writeback,
                        got.way, want.way, m_tdata[OUT_W-1:5]));
            end
        end
    end

    initial
    begin : stimulus
        stim_row_t   rows[$];
        logic [31:0] pool[$];
        logic [4:0]  off;
        logic [3:0]  idx;
        logic [3:0]  ways;
        logic [63:0] base;
        logic [63:0] offmask;
        logic [31:0] addr;
        int          pool_size;
        int          sets_used;

        foreach (tag_mem[s, w])
        begin
            tag_mem[s][w]    = '0;
            line_valid[s][w] = 1'b0;
            line_dirty[s][w] = 1'b0;
        end
        foreach (next_victim[s])
            next_victim[s] = 0;

        // reset geometry: one set, one way, 16-byte lines
        // a zero tag is not a hit while the line is still invalid
        rows.push_back(pinned_row(32'h0000_0000, LOAD,  1'b0, 1'b0, 3'd0));
        rows.push_back(pinned_row(32'h0000_000f, LOAD,  1'b1, 1'b0, 3'd0));
        rows.push_back(pinned_row(32'h0000_0004, STORE, 1'b1, 1'b0, 3'd0));
        rows.push_back(pinned_row(32'hffff_ffff, LOAD,  1'b0, 1'b1, 3'd0));
        rows.push_back(pinned_row(32'hffff_fff0, STORE, 1'b1, 1'b0, 3'd0));
        rows.push_back(pinned_row(32'h0000_0010, STORE, 1'b0, 1'b1, 3'd0));
        rows.push_back(pinned_row(32'h0000_0010, LOAD,  1'b1, 1'b0, 3'd0));
        rows.push_back(pinned_row(32'h8000_0000, LOAD,  1'b0, 1'b1, 3'd0));
        rows.push_back(pinned_row(32'h0000_0000, LOAD,  1'b0, 1'b0, 3'd0));
        // eight ways, old lines kept across the change, all accesses in one set
        rows.push_back(geometry_row(5'd0, 4'd8, 4'd8));
        rows.push_back(access_row(32'h0000_0000, STORE));
        rows.push_back(access_row(32'h0000_0100, STORE));
        rows.push_back(access_row(32'h0000_0200, STORE));
        rows.push_back(access_row(32'h0000_0300, LOAD));
        rows.push_back(access_row(32'h0000_0400, STORE));
        rows.push_back(access_row(32'h0000_0500, STORE));
        // shrink to three ways: stale victim pointer, lines outside the ways unseen
        rows.push_back(geometry_row(5'd0, 4'd8, 4'd3));
        rows.push_back(access_row(32'h0000_0700, LOAD));
        rows.push_back(access_row(32'h0000_0100, LOAD));
        rows.push_back(access_row(32'h0000_0500, STORE));
        // widest offset and index, zero ways
        rows.push_back(geometry_row(5'd31, 4'd15, 4'd0));
        rows.push_back(access_row(32'h8000_0000, STORE));
        rows.push_back(access_row(32'h0000_0000, LOAD));
        rows.push_back(access_row(32'h7fff_ffff, LOAD));
        // ways above the maximum saturate
        rows.push_back(geometry_row(5'd16, 4'd0, 4'd15));
        rows.push_back(access_row(32'hffff_0000, STORE));
        rows.push_back(access_row(32'h1234_5678, LOAD));
        rows.push_back(access_row(32'hffff_ffff, LOAD));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (rows[i])
        begin
            if (rows[i].geometry)
            begin
                drain();
                set_geometry(rows[i].off, rows[i].idx, rows[i].ways);
            end
            else
            begin
                if ($urandom_range(0, 5) == 0)
                    idle_gap($urandom_range(1, 19));
                send_access(rows[i].addr, rows[i].store, rows[i].pinned, rows[i].res);
            end
        end

        // random phases, each with its own geometry and a small set of hot lines
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            case (p)
                0: {off, idx, ways} = {5'd0, 4'd0, 4'd1};
                1: {off, idx, ways} = {5'd16, 4'd8, 4'd8};
                2: {off, idx, ways} = {5'd31, 4'd15, 4'd15};
                3: {off, idx, ways} = {5'd0, 4'd15, 4'd0};
                default:
                begin
                    off  = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(17, 31))
                                                       : 5'($urandom_range(0, 16));
                    idx  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(9, 15))
                                                       : 4'($urandom_range(0, 8));
                    ways = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 16))
                                                       : 4'($urandom_range(1, 8));
                end
            endcase
            set_geometry(off, idx, ways);
            calm = (p == PHASES - 1);

            // hot lines crowd into a few sets so that ways fill and evict
            pool.delete();
            pool_size = $urandom_range(2, 16);
            sets_used = $urandom_range(1, 4);
            repeat (pool_size)
            begin
                base = (64'($urandom) << (int'(off) + int'(idx)))
                     | (64'($urandom_range(0, sets_used - 1)) << off);
                pool.push_back(base[31:0]);
            end
            offmask = (64'd1 << off) - 64'd1;

            repeat (PHASE_BEATS)
            begin
                if (!calm && $urandom_range(0, 5) == 0)
                    idle_gap($urandom_range(1, 19));
                if ($urandom_range(0, 3) != 0)
                    addr = pool[$urandom_range(0, pool.size() - 1)] | ($urandom & offmask[31:0]);
                else
                    addr = $urandom;
                send_access(addr, 1'($urandom_range(0, 1)), 1'b0, '0);
            end
        end

        drain();
        if (due_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", due_results.size()));
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog
    initial
    begin
        #1000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
